// ----- rtl/pcm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_pkg
// Types and constants shared by the pixel channel mapper modules.
// ----------------------------------------------------------------------------
package pcm_pkg;

    // field widths
    localparam int CH_W      = 12;
    localparam int VAL_W     = 8;
    localparam int GIDX_W    = 8;
    localparam int OADDR_W   = 12;
    localparam int BPP_W     = 3;
    localparam int COFF_W    = 8;
    localparam int ZIG_W     = 13;
    localparam int GRP_W     = 7;
    localparam int BRI_W     = 9;
    localparam int BUF_W     = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam int GAMMA_DEPTH = 256;

    // pixel index after the divide by bytes per pixel
    localparam int PIX_W = 11;
    // pixel index after zig-zag folding
    localparam int FPIX_W = 14;
    // internal byte address, wide enough for pixel * group * bpp + offset
    localparam int ADDR_W = 24;

    // zig-zag divider: one quotient bit per cycle
    localparam int DIV_STEPS = PIX_W;
    localparam int DIV_CNT_W = 4;

    // floor(ch / 3) as (ch * RECIP3) >> RECIP3_SHIFT for 12-bit ch
    localparam logic [CH_W-1:0] RECIP3       = 12'd2731;
    localparam int              RECIP3_SHIFT = 13;

    localparam int SCALE_SHIFT = 8;

    // register reset values
    localparam logic [BPP_W-1:0]  BPP_RST  = 3'd3;
    localparam logic [COFF_W-1:0] COFF_RST = 8'd228;
    localparam logic [ZIG_W-1:0]  ZIG_RST  = 13'd1;
    localparam logic [GRP_W-1:0]  GRP_RST  = 7'd1;
    localparam logic [BRI_W-1:0]  BRI_RST  = 9'd256;
    localparam logic [BUF_W-1:0]  BUF_RST  = 13'd4096;

    localparam logic [BPP_W-1:0] BPP_FOUR  = 3'd4;
    localparam logic [BRI_W-1:0] BRI_FULL  = 9'd256;

    // item kinds on the input tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BPP    = 3'd0,
        CFG_COFF   = 3'd1,
        CFG_ZIG    = 3'd2,
        CFG_GROUP  = 3'd3,
        CFG_BRIGHT = 3'd4,
        CFG_BUFFER = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [BPP_W-1:0]  bytes_per_pixel;
        logic [COFF_W-1:0] color_offsets;
        logic [ZIG_W-1:0]  zigzag_size;
        logic [GRP_W-1:0]  group_size;
        logic [BRI_W-1:0]  brightness_scale;
        logic [BUF_W-1:0]  buffer_bytes;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_FOLD,
        ST_SCALE,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_step;
        logic fold;
        logic scale;
        logic emit_map;
        logic emit_null;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic div_last;
        logic emit_done;
    } sts_t;

endpackage : pcm_pkg
`default_nettype wire

// ----- rtl/pcm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_ctrl
// Sequencer for one item: capture, then for a map divide, fold, scale and emit beats, or for a load emit one beat.
// ----------------------------------------------------------------------------
module pcm_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_op,
    output logic              in_ready,
    input  wire pcm_pkg::sts_t sts,
    output pcm_pkg::cmd_t     cmd
);
    import pcm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (in_op == OP_MAP) ? ST_DIV : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_null = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_map = 1'b1;
                    if (sts.emit_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : pcm_ctrl
`default_nettype wire

// ----- rtl/pcm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_dp
// Datapath: gamma memory, channel split, zig-zag divider, address and
// intensity arithmetic, copy counter and output register.
// ----------------------------------------------------------------------------
module pcm_dp #(
    parameter int BUFFER_DEPTH = 4096,
    parameter int MAX_GROUP    = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pcm_pkg::cmd_t                  cmd,
    output pcm_pkg::sts_t                       sts,
    input  wire pcm_pkg::cfg_t                  cfg,
    input  wire logic [pcm_pkg::IN_DATA_W-1:0]  in_data,
    input  wire logic                           in_op,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic [pcm_pkg::OUT_DATA_W-1:0]      out_data,
    output logic                                out_user,
    output logic                                out_last
);
    import pcm_pkg::*;

    localparam logic [ADDR_W-1:0] DEPTH_LIM = ADDR_W'(BUFFER_DEPTH);
    localparam logic [GRP_W-1:0]  GRP_MAX   = GRP_W'(MAX_GROUP);

    // input fields
    logic [CH_W-1:0]   in_ch;
    logic [VAL_W-1:0]  in_val;
    logic [GIDX_W-1:0] in_gidx;
    assign in_ch   = in_data[CH_W-1:0];
    assign in_val  = in_data[CH_W+VAL_W-1:CH_W];
    assign in_gidx = in_data[CH_W+VAL_W+GIDX_W-1:CH_W+VAL_W];

    // clamped configuration
    logic              bpp_four;
    logic [2:0]        bpp;
    logic [GRP_W-1:0]  grp;
    logic [BRI_W-1:0]  bri;
    logic [ADDR_W-1:0] buf_ext;
    logic [ADDR_W-1:0] limit;
    logic              zig_on;

    assign bpp_four = (cfg.bytes_per_pixel == BPP_FOUR);
    assign bpp      = bpp_four ? 3'd4 : 3'd3;
    assign bri      = (cfg.brightness_scale > BRI_FULL) ? BRI_FULL : cfg.brightness_scale;
    assign buf_ext  = ADDR_W'(cfg.buffer_bytes);
    assign limit    = (buf_ext < DEPTH_LIM) ? buf_ext : DEPTH_LIM;
    assign zig_on   = (cfg.zigzag_size > ZIG_W'(1));

    always_comb
    begin
        priority if (cfg.group_size == '0)
        begin
            grp = GRP_W'(1);
        end
        else if (cfg.group_size > GRP_MAX)
        begin
            grp = GRP_MAX;
        end
        else
        begin
            grp = cfg.group_size;
        end
    end

    // gamma memory, written by load beats, read at capture
    logic [VAL_W-1:0] gamma_mem [GAMMA_DEPTH];
    logic [VAL_W-1:0] gamma_q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            if (in_op == OP_LOAD)
            begin
                gamma_mem[in_gidx] <= in_val;
            end
            gamma_q_reg <= gamma_mem[in_val];
        end
    end

    // channel split into pixel and colour slot
    logic [2*CH_W-1:0] ch_prod;
    logic [PIX_W-1:0]  pix_div3;
    logic [CH_W-1:0]   rem3_full;
    logic [PIX_W-1:0]  pix_split;
    logic [1:0]        col_split;

    assign ch_prod   = in_ch * RECIP3;
    assign pix_div3  = ch_prod[RECIP3_SHIFT+PIX_W-1:RECIP3_SHIFT];
    assign rem3_full = in_ch - (CH_W'(pix_div3) + CH_W'({pix_div3, 1'b0}));
    assign pix_split = bpp_four ? PIX_W'(in_ch >> 2) : pix_div3;
    assign col_split = bpp_four ? in_ch[1:0] : rem3_full[1:0];

    // zig-zag divider: pixel / zigzag_size, restoring, one bit per cycle
    logic [PIX_W-1:0]     pix_reg;
    logic [1:0]           col_reg;
    logic [PIX_W-1:0]     quo_reg;
    logic [PIX_W-1:0]     quo_next;
    logic [ZIG_W-1:0]     rem_reg;
    logic [ZIG_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [ZIG_W:0]       trial;
    logic                 trial_ge;

    assign trial    = {rem_reg, quo_reg[PIX_W-1]};
    assign trial_ge = (trial >= {1'b0, cfg.zigzag_size});

    always_comb
    begin
        quo_next = {quo_reg[PIX_W-2:0], trial_ge};
        rem_next = trial_ge ? ZIG_W'(trial - {1'b0, cfg.zigzag_size}) : trial[ZIG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.capture)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= pix_split;
            col_reg <= col_split;
            quo_reg <= pix_split;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // fold odd runs and scale intensity
    logic [FPIX_W-1:0]        fpix;
    logic [FPIX_W+GRP_W-1:0]  pg_reg;
    logic [VAL_W+BRI_W-1:0]   inten_prod;
    logic [VAL_W-1:0]         inten_reg;

    assign fpix = (zig_on && quo_reg[0])
                ? FPIX_W'(FPIX_W'(pix_reg) + FPIX_W'(cfg.zigzag_size) - FPIX_W'(1)
                          - FPIX_W'({rem_reg, 1'b0}))
                : FPIX_W'(pix_reg);
    assign inten_prod = gamma_q_reg * bri;

    always_ff @(posedge clk)
    begin
        if (cmd.fold)
        begin
            pg_reg <= fpix * grp;
            if (inten_prod[VAL_W+BRI_W-1:SCALE_SHIFT] > (VAL_W+BRI_W-SCALE_SHIFT)'(8'hFF))
            begin
                inten_reg <= 8'hFF;
            end
            else
            begin
                inten_reg <= inten_prod[SCALE_SHIFT+VAL_W-1:SCALE_SHIFT];
            end
        end
    end

    // base address and copy walk
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_step;
    logic [ADDR_W-1:0] pg_ext;
    logic [1:0]        coff;
    logic [GRP_W-1:0]  kcnt_reg;
    logic              at_end;
    logic              last_copy;

    assign pg_ext    = ADDR_W'(pg_reg);
    assign coff      = cfg.color_offsets[{col_reg, 1'b0} +: 2];
    assign addr_step = addr_reg + ADDR_W'(bpp);
    assign at_end    = (addr_reg >= limit);
    assign last_copy = (kcnt_reg == grp - GRP_W'(1)) || (addr_step >= limit);

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            addr_reg <= (bpp_four ? {pg_ext[ADDR_W-3:0], 2'b00}
                                  : ADDR_W'({pg_ext[ADDR_W-2:0], 1'b0} + pg_ext))
                        + ADDR_W'(coff);
            kcnt_reg <= '0;
        end
        else if (cmd.emit_map)
        begin
            addr_reg <= addr_step;
            kcnt_reg <= kcnt_reg + GRP_W'(1);
        end
    end

    // output register
    logic                  ovalid_reg;
    logic [OADDR_W-1:0]    oaddr_reg;
    logic [VAL_W-1:0]      oint_reg;
    logic                  owv_reg;
    logic                  olast_reg;
    logic                  emit_any;
    logic                  emit_write;

    assign emit_any   = cmd.emit_map || cmd.emit_null;
    assign emit_write = cmd.emit_map && !at_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (emit_any)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            owv_reg   <= emit_write;
            oaddr_reg <= emit_write ? addr_reg[OADDR_W-1:0] : '0;
            oint_reg  <= emit_write ? inten_reg : '0;
            olast_reg <= emit_write ? last_copy : 1'b1;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = {4'b0000, oint_reg, oaddr_reg};
    assign out_user  = owv_reg;
    assign out_last  = olast_reg;

    // status
    assign sts.out_free  = !ovalid_reg || out_ready;
    assign sts.div_last  = (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.emit_done = at_end || last_copy;

endmodule : pcm_dp
`default_nettype wire

// ----- rtl/pixel_channel_mapper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_channel_mapper
// Maps one lighting channel beat onto pixel buffer byte writes.
// ----------------------------------------------------------------------------
// Input stream: tuser selects a gamma entry load (0) or a channel map (1);
// tdata carries channel, value and gamma index. Output stream: tdata carries
// address and intensity, tuser is the write flag, tlast marks the final beat
// of each input. The configuration port writes one register per enabled
// clock edge; it is to be written only while the block is idle, and the
// block itself does not enforce this. A load beat passes from capture
// through the load state into the output register. A map beat runs a capture
// step, the bit-serial zig-zag divider, a fold and an address step, then one
// result per cycle while the receiver accepts, for each copy (up to
// group_size, at most MAX_GROUP, and stopping at the buffer end).
// A new input is taken once the last result sits in the output register.
// When the receiver stalls, the output register holds and the sequencer
// waits. Reset clears control state and restores register defaults; the
// gamma table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module pixel_channel_mapper #(
    parameter int BUFFER_DEPTH = 4096,
    parameter int MAX_GROUP    = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // beat in
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [pcm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // channel, value, gamma_index
    input  wire logic                             s_axis_tuser,  // op
    // beat out
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic [pcm_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // address, intensity
    output logic                                  m_axis_tuser,  // write_valid
    output logic                                  m_axis_tlast,
    // register writes
    input  wire logic                             cfg_we,
    input  wire logic [pcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcm_pkg::CFG_DAT_W-1:0]    cfg_wdata
);
    import pcm_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_pixel  <= BPP_RST;
            cfg_reg.color_offsets    <= COFF_RST;
            cfg_reg.zigzag_size      <= ZIG_RST;
            cfg_reg.group_size       <= GRP_RST;
            cfg_reg.brightness_scale <= BRI_RST;
            cfg_reg.buffer_bytes     <= BUF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BPP:    cfg_reg.bytes_per_pixel  <= cfg_wdata[BPP_W-1:0];
                CFG_COFF:   cfg_reg.color_offsets    <= cfg_wdata[COFF_W-1:0];
                CFG_ZIG:    cfg_reg.zigzag_size      <= cfg_wdata[ZIG_W-1:0];
                CFG_GROUP:  cfg_reg.group_size       <= cfg_wdata[GRP_W-1:0];
                CFG_BRIGHT: cfg_reg.brightness_scale <= cfg_wdata[BRI_W-1:0];
                CFG_BUFFER: cfg_reg.buffer_bytes     <= cfg_wdata[BUF_W-1:0];
                default:    ;
            endcase
        end
    end

    // sequencer
    pcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    pcm_dp #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_GROUP    (MAX_GROUP)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg       (cfg_reg),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule : pixel_channel_mapper
`default_nettype wire
